>>> rtl/core/psg_pkg.sv
// Shared types, constants and the level ROM function for the three-tone sound generator.
// Used by every module of the block; depends on nothing else.
package psg_pkg;

  // Chip register file size.
  localparam int NUM_CHIP_REGS = 16;

  // Configuration port.
  localparam int TICK_W    = 26;
  localparam int AMP_W     = 5;
  localparam int MODE_W    = 2;
  localparam int CFG_W     = 26;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 2'd2;

  localparam logic [MODE_W-1:0] STEREO_ACB = 2'd2;

  localparam logic [TICK_W-1:0] TICK_RESET = 26'd3328000;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 5'd31;

  // Input command codes.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Chip register numbers.
  localparam logic [3:0] REG_TONE_LAST  = 4'd5;
  localparam logic [3:0] REG_NOISE      = 4'd6;
  localparam logic [3:0] REG_MIXER      = 4'd7;
  localparam logic [3:0] REG_LEVEL_A    = 4'd8;
  localparam logic [3:0] REG_LEVEL_B    = 4'd9;
  localparam logic [3:0] REG_LEVEL_C    = 4'd10;
  localparam logic [3:0] REG_ENV_FINE   = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;

  // Channel numbers; a sample visits them in the order C, A, B.
  localparam logic [1:0] CH_A = 2'd0;
  localparam logic [1:0] CH_B = 2'd1;
  localparam logic [1:0] CH_C = 2'd2;

  // Datapath constants.
  localparam logic [31:0] ENV_SUB_WRAP = 32'h0100_0000;
  localparam logic [7:0]  MIX_MID      = 8'h80;
  localparam logic [16:0] LFSR_RESET   = 17'd1;

  // Shared divider widths.
  localparam int DIV_N_W   = 38;
  localparam int DIV_D_W   = 32;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  // Attenuation per 3 dB step, Q16.
  localparam logic [16:0] ATT_Q16 [15] = '{
    17'd65536, 17'd46396, 17'd32846, 17'd23253, 17'd16462, 17'd11654, 17'd8250, 17'd5841,
    17'd4135, 17'd2927, 17'd2072, 17'd1467, 17'd1039, 17'd735, 17'd521
  };

  typedef struct packed {
    logic       cmd;
    logic [3:0] reg_addr;
    logic [7:0] reg_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] left_sample;
    logic [7:0] right_sample;
  } out_item_t;

  // Operand selection for the shared divider.
  typedef enum logic [1:0] {
    DIV_MOD = 2'd0,
    DIV_ENV = 2'd1,
    DIV_SUB = 2'd2
  } div_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       reg_write;
    logic       div_start;
    div_sel_t   div_sel;
    logic       mod_apply;
    logic       env_apply;
    logic       ch_step1;
    logic       ch_step2;
    logic       sub_apply;
    logic       sub_neg;
    logic       ch_store;
    logic       finish;
    logic [1:0] ch;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_mod;
    logic env_eval;
    logic ch_enabled;
    logic need_sub1;
    logic need_sub2;
    logic div_done;
    logic out_free;
  } ctrl_status_t;

  // Volume ROM entry for a given peak amplitude; entry zero is silence.
  function automatic logic [AMP_W-1:0] level_rom(input logic [AMP_W-1:0] amp,
                                                 input logic [3:0] idx);
    logic [21:0] prod;
    if (idx == 4'd0) begin
      return '0;
    end
    prod = 22'(amp) * 22'(ATT_Q16[4'd15 - idx]) + 22'd32768;
    return prod[20:16];
  endfunction

endpackage

>>> rtl/core/psg_div.sv
// Shared restoring divider: one quotient bit per cycle, quotient and remainder held until restart.
// Depends on psg_pkg for its widths.
module psg_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [psg_pkg::DIV_N_W-1:0]  dividend,
  input  logic [psg_pkg::DIV_D_W-1:0]  divisor,
  output logic [psg_pkg::DIV_N_W-1:0]  quotient,
  output logic [psg_pkg::DIV_D_W-1:0]  remainder,
  output logic                         done
);
  import psg_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_D_W-1:0]   dsr;
  logic [DIV_D_W:0]     rem_sh;
  logic                 fits;

  // Shift in the next dividend bit and try a subtraction.
  assign rem_sh = {remainder, quotient[DIV_N_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_N_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DIV_N_W-2:0], fits};
      if (fits) begin
        remainder <= DIV_D_W'(rem_sh - {1'b0, dsr});
      end else begin
        remainder <= rem_sh[DIV_D_W-1:0];
      end
    end
  end

endmodule

>>> rtl/core/psg_datapath.sv
// Datapath of the sound generator: chip registers, tone, noise and envelope state, mixer, output.
// Depends on psg_pkg and instantiates psg_div.
module psg_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  psg_pkg::in_item_t              in_data,
  input  logic                           cfg_wr_en,
  input  logic [psg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psg_pkg::CFG_W-1:0]      cfg_data,
  input  psg_pkg::ctrl_cmd_t             cmd,
  output psg_pkg::ctrl_status_t          status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output psg_pkg::out_item_t             out_data
);
  import psg_pkg::*;

  // Configuration.
  logic [TICK_W-1:0] tick;
  logic [AMP_W-1:0]  amp;
  logic [MODE_W-1:0] stereo;

  // Chip state.
  logic [7:0]  chip_regs [NUM_CHIP_REGS];
  logic [31:0] tone_phase [3];
  logic [31:0] tone_period [3];
  logic [31:0] noise_phase, noise_period;
  logic [16:0] lfsr;
  logic        noise_bit;
  logic [15:0] env_step, env_period;
  logic [31:0] env_subcount;
  logic        env_hold, env_flip;
  logic [AMP_W-1:0] env_out_level;

  // Current transaction and per-channel work registers.
  logic        sample_mode;
  logic [3:0]  item_addr;
  logic [7:0]  item_data;
  logic [AMP_W-1:0] ch_level;
  logic [AMP_W-1:0] env_sample_level;
  logic [7:0]  ch_d;
  logic [31:0] ph1, sub_x;
  logic        need1, need2;
  logic [7:0]  acc [3];

  // Divider.
  logic                 div_start;
  logic [DIV_N_W-1:0]   div_num, div_quo;
  logic [DIV_D_W-1:0]   div_den, div_rem;
  logic                 div_done;

  logic [31:0] tick32;
  logic [1:0]  ch_idx;
  logic [31:0] cur_phase, cur_period, period2;
  logic        is_tone;
  logic [7:0]  pair_lo, pair_hi, lo_new, hi_new;
  logic [31:0] new_period;
  logic [19:0] step15;

  logic [7:0]  shape, mixer;
  logic        env_eval;
  logic [3:0]  v_raw, v1, v;
  logic [AMP_W-1:0] env_lvl_a, env_lvl_b;
  logic [31:0] sc_sum, sc_next;
  logic [16:0] st_inc, st_next;
  logic        sc_wrap, st_wrap, hold_set, hold_next;

  logic [7:0]  lvl_reg;
  logic [AMP_W-1:0] lvl_src, lvl;
  logic        tone_dis, noise_dis;
  logic [31:0] ph1_c, ph2;
  logic        high, wrap;

  logic [7:0]  left_c, right_c;
  logic [31:0] np_sum;

  assign tick32     = {{(32-TICK_W){1'b0}}, tick};
  assign ch_idx     = sample_mode ? cmd.ch : item_addr[2:1];
  assign cur_phase  = tone_phase[ch_idx];
  assign cur_period = tone_period[ch_idx];
  assign period2    = {cur_period[30:0], 1'b0};
  assign is_tone    = item_addr <= REG_TONE_LAST;
  assign shape      = chip_regs[REG_ENV_SHAPE];
  assign mixer      = chip_regs[REG_MIXER];
  assign step15     = 20'(env_step) * 20'd15;

  // Fine and coarse bytes of the channel being written, merged with the new byte.
  always_comb begin
    case (item_addr[2:1])
      CH_A:    begin pair_lo = chip_regs[0]; pair_hi = chip_regs[1]; end
      CH_B:    begin pair_lo = chip_regs[2]; pair_hi = chip_regs[3]; end
      CH_C:    begin pair_lo = chip_regs[4]; pair_hi = chip_regs[5]; end
      default: begin pair_lo = '0; pair_hi = '0; end
    endcase
    lo_new = item_addr[0] ? pair_lo : item_data;
    hi_new = item_addr[0] ? item_data : pair_hi;
  end
  assign new_period = {1'b0, hi_new[3:0], lo_new, 3'b000, 16'h0000};

  // Divider operand selection.
  always_comb begin
    case (cmd.div_sel)
      DIV_MOD: begin
        div_num = {6'b0, cur_phase};
        div_den = period2;
      end
      DIV_ENV: begin
        div_num = {18'b0, step15};
        div_den = {16'b0, env_period};
      end
      DIV_SUB: begin
        div_num = DIV_N_W'({ch_level, 1'b0}) * DIV_N_W'(sub_x);
        div_den = tick32;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end
  assign div_start = cmd.div_start;

  psg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  // Envelope level from the ratio, then the envelope advance for this sample.
  always_comb begin
    env_eval  = (env_period != 16'd0) && !env_hold;
    v_raw     = (|div_quo[DIV_N_W-1:4]) ? 4'd15 : div_quo[3:0];
    v1        = shape[2] ? v_raw : 4'd15 - v_raw;
    v         = env_eval ? (env_flip ? 4'd15 - v1 : v1) : 4'd0;
    env_lvl_a = env_eval ? level_rom(amp, v) : env_out_level;
    env_lvl_b = env_lvl_a;
    sc_sum    = env_subcount + tick32;
    sc_wrap   = sc_sum >= ENV_SUB_WRAP;
    sc_next   = sc_wrap ? sc_sum - ENV_SUB_WRAP : sc_sum;
    st_inc    = {1'b0, env_step} + 17'd1;
    st_wrap   = (env_period != 16'd0) && sc_wrap && (st_inc >= {1'b0, env_period});
    st_next   = st_wrap ? st_inc - {1'b0, env_period} : st_inc;
    hold_set  = st_wrap && !env_hold && (shape[0] || !shape[3]);
    hold_next = env_hold || hold_set;
    if (hold_set && (shape[1] || shape[3:2] == 2'b01)) begin
      env_lvl_b = level_rom(amp, 4'd15 - v);
    end
  end

  // Level and gating of the channel being processed.
  always_comb begin
    case (cmd.ch)
      CH_A:    lvl_reg = chip_regs[REG_LEVEL_A];
      CH_B:    lvl_reg = chip_regs[REG_LEVEL_B];
      CH_C:    lvl_reg = chip_regs[REG_LEVEL_C];
      default: lvl_reg = '0;
    endcase
    tone_dis  = mixer[cmd.ch];
    noise_dis = mixer[3'({1'b0, cmd.ch}) + 3'd3];
    lvl_src   = lvl_reg[4] ? env_sample_level : level_rom(amp, lvl_reg[3:0]);
    lvl       = (noise_bit || noise_dis) ? lvl_src : '0;
    high      = (lvl != '0) && (cur_phase >= cur_period);
    ph1_c     = cur_phase + tick32;
    wrap      = ph1 >= period2;
    ph2       = ph1 - period2;
  end

  // Mixer.
  always_comb begin
    if (stereo == STEREO_ACB) begin
      left_c  = MIX_MID + acc[CH_C] + acc[CH_A];
      right_c = MIX_MID + acc[CH_C] + acc[CH_B];
    end else begin
      left_c  = MIX_MID + acc[CH_C] + acc[CH_A] + acc[CH_B];
      right_c = left_c;
    end
  end
  assign np_sum = noise_phase + tick32;

  // Status for the controller.
  always_comb begin
    status.need_mod   = is_tone && (cur_period != 32'd0) && (cur_phase >= period2);
    status.env_eval   = env_eval;
    status.ch_enabled = !tone_dis || !noise_dis;
    status.need_sub1  = need1;
    status.need_sub2  = need2;
    status.div_done   = div_done;
    status.out_free   = !out_valid || out_ready;
  end

  // State with reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick         <= TICK_RESET;
      amp          <= AMP_RESET;
      stereo       <= '0;
      for (int i = 0; i < NUM_CHIP_REGS; i++) begin
        chip_regs[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        tone_phase[i]  <= '0;
        tone_period[i] <= '0;
      end
      noise_phase  <= '0;
      noise_period <= '0;
      lfsr         <= LFSR_RESET;
      noise_bit    <= 1'b1;
      env_step     <= '0;
      env_subcount <= '0;
      env_period   <= '0;
      env_hold     <= 1'b0;
      env_flip     <= 1'b0;
      env_out_level <= '0;
      out_valid    <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_TICK:   tick   <= cfg_data[TICK_W-1:0];
          CFG_AMP:    amp    <= cfg_data[AMP_W-1:0];
          CFG_STEREO: stereo <= cfg_data[MODE_W-1:0];
          default:    ;
        endcase
      end

      // Chip register write and its side effects.
      if (cmd.reg_write && ({1'b0, item_addr} < 5'(NUM_CHIP_REGS))) begin
        chip_regs[item_addr] <= item_data;
        if (is_tone) begin
          tone_period[ch_idx] <= new_period;
        end
        case (item_addr)
          REG_NOISE: begin
            noise_phase  <= '0;
            noise_period <= {7'b0, item_data[4:0], 4'b0, 16'h0000};
          end
          REG_ENV_FINE:   env_period <= {chip_regs[REG_ENV_COARSE], item_data};
          REG_ENV_COARSE: env_period <= {item_data, chip_regs[REG_ENV_FINE]};
          REG_ENV_SHAPE: begin
            env_step     <= '0;
            env_subcount <= '0;
            env_hold     <= 1'b0;
            env_flip     <= 1'b0;
            env_out_level <= '0;
          end
          default: ;
        endcase
      end

      // Phase reduction after a tone period change.
      if (cmd.mod_apply) begin
        tone_phase[ch_idx] <= div_rem;
      end

      // Envelope level and advance.
      if (cmd.env_apply) begin
        env_out_level <= env_lvl_b;
        if (env_period != 16'd0) begin
          env_subcount <= sc_next;
          if (sc_wrap) begin
            env_step <= st_next[15:0];
          end
          env_hold <= hold_next;
          if (st_wrap && !hold_next && shape[1]) begin
            env_flip <= !env_flip;
          end
        end
      end

      // Phase wrap at the end of a channel's half cycle pair.
      if (cmd.ch_step2) begin
        tone_phase[ch_idx] <= wrap ? ph2 : ph1;
      end

      // Output register and noise generator advance.
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (np_sum >= noise_period) begin
          if (lfsr[0] ^ lfsr[1]) begin
            noise_bit <= !noise_bit;
          end
          lfsr        <= {lfsr[0] ^ lfsr[2], lfsr[16:1]};
          noise_phase <= np_sum - noise_period;
        end else begin
          noise_phase <= np_sum;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Work registers of the current transaction.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_mode <= in_data.cmd;
      item_addr   <= in_data.reg_addr;
      item_data   <= in_data.reg_data;
      for (int i = 0; i < 3; i++) begin
        acc[i] <= '0;
      end
    end
    // Channels of this sample use the envelope level before the advance.
    if (cmd.env_apply) begin
      env_sample_level <= env_lvl_a;
    end
    if (cmd.ch_step1) begin
      ch_level <= lvl;
      if (lvl == '0) begin
        ch_d <= '0;
      end else if (high) begin
        ch_d <= 8'(lvl);
      end else begin
        ch_d <= 8'd0 - 8'(lvl);
      end
      ph1   <= ph1_c;
      sub_x <= ph1_c - cur_period;
      need1 <= (lvl != '0) && !high && (ph1_c >= cur_period) && (tick != '0);
    end
    if (cmd.ch_step2) begin
      sub_x <= ph2;
      need2 <= wrap && (ch_level != '0) && (ph2 < cur_period) && (tick != '0);
    end
    if (cmd.sub_apply) begin
      ch_d <= cmd.sub_neg ? ch_d - div_quo[7:0] : ch_d + div_quo[7:0];
    end
    if (cmd.ch_store) begin
      acc[cmd.ch] <= ch_d;
    end
    if (cmd.finish) begin
      out_data.left_sample  <= left_c;
      out_data.right_sample <= right_c;
    end
  end

endmodule

>>> rtl/core/psg_ctrl.sv
// Controller state machine: sequences register writes, divisions and the three channels of a sample.
// Depends on psg_pkg for the command and status structs.
module psg_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_cmd,
  output logic                   in_ready,
  input  psg_pkg::ctrl_status_t  status,
  output psg_pkg::ctrl_cmd_t     cmd
);
  import psg_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_WRITE    = 15'b000000000000010,
    S_MODCHK   = 15'b000000000000100,
    S_MODWAIT  = 15'b000000000001000,
    S_ENVCHK   = 15'b000000000010000,
    S_ENVWAIT  = 15'b000000000100000,
    S_ENVAPPLY = 15'b000000001000000,
    S_CHSTEP1  = 15'b000000010000000,
    S_CHSUB1   = 15'b000000100000000,
    S_SUB1WAIT = 15'b000001000000000,
    S_CHSTEP2  = 15'b000010000000000,
    S_CHSUB2   = 15'b000100000000000,
    S_SUB2WAIT = 15'b001000000000000,
    S_CHEND    = 15'b010000000000000,
    S_OUT      = 15'b100000000000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] ch, ch_next;
  logic [1:0] ch_after;
  logic       ch_last;

  // Channel order C, A, B.
  assign ch_last  = ch == CH_B;
  assign ch_after = (ch == CH_C) ? CH_A : CH_B;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= CH_C;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    ch_next    = ch;
    cmd        = '0;
    cmd.ch     = ch;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          ch_next    = CH_C;
          state_next = (in_cmd == CMD_SAMPLE) ? S_ENVCHK : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.reg_write = 1'b1;
        state_next    = S_MODCHK;
      end
      S_MODCHK: begin
        cmd.div_sel = DIV_MOD;
        if (status.need_mod) begin
          cmd.div_start = 1'b1;
          state_next    = S_MODWAIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MODWAIT: begin
        if (status.div_done) begin
          cmd.mod_apply = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_ENVCHK: begin
        cmd.div_sel = DIV_ENV;
        if (status.env_eval) begin
          cmd.div_start = 1'b1;
          state_next    = S_ENVWAIT;
        end else begin
          state_next = S_ENVAPPLY;
        end
      end
      S_ENVWAIT: begin
        if (status.div_done) begin
          state_next = S_ENVAPPLY;
        end
      end
      S_ENVAPPLY: begin
        cmd.env_apply = 1'b1;
        state_next    = S_CHSTEP1;
      end
      S_CHSTEP1: begin
        if (status.ch_enabled) begin
          cmd.ch_step1 = 1'b1;
          state_next   = S_CHSUB1;
        end else if (ch_last) begin
          state_next = S_OUT;
        end else begin
          ch_next = ch_after;
        end
      end
      S_CHSUB1: begin
        cmd.div_sel = DIV_SUB;
        if (status.need_sub1) begin
          cmd.div_start = 1'b1;
          state_next    = S_SUB1WAIT;
        end else begin
          state_next = S_CHSTEP2;
        end
      end
      S_SUB1WAIT: begin
        if (status.div_done) begin
          cmd.sub_apply = 1'b1;
          state_next    = S_CHSTEP2;
        end
      end
      S_CHSTEP2: begin
        cmd.ch_step2 = 1'b1;
        state_next   = S_CHSUB2;
      end
      S_CHSUB2: begin
        cmd.div_sel = DIV_SUB;
        if (status.need_sub2) begin
          cmd.div_start = 1'b1;
          state_next    = S_SUB2WAIT;
        end else begin
          state_next = S_CHEND;
        end
      end
      S_SUB2WAIT: begin
        if (status.div_done) begin
          cmd.sub_apply = 1'b1;
          cmd.sub_neg   = 1'b1;
          state_next    = S_CHEND;
        end
      end
      S_CHEND: begin
        cmd.ch_store = 1'b1;
        if (ch_last) begin
          state_next = S_OUT;
        end else begin
          ch_next    = ch_after;
          state_next = S_CHSTEP1;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/psg_three_tone_noise_envelope.sv
// Register write: stores the register, then reduces the tone phase by the new period when needed.
// Sample request: evaluates the envelope, then steps each enabled channel in turn; the shared
// 38-bit divider serves one division for the envelope ratio and up to two per channel for the
// edge correction, and the result may wait on an output stall.
// One transaction is in work at a time; the output register frees the input while a result waits.
// Synchronous active-high reset loads the power-on chip state and the default configuration.
module psg_three_tone_noise_envelope (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  psg_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output psg_pkg::out_item_t             out_data,
  input  logic                           cfg_wr_en,
  input  logic [psg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psg_pkg::CFG_W-1:0]      cfg_data
);
  import psg_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequencer.
  psg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and state.
  psg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/psg_checker.sv
// Port-level assertions for the sound generator, attached to the top level by a bind.
// Depends on psg_pkg for the payload types.
module psg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input psg_pkg::in_item_t              in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input psg_pkg::out_item_t             out_data,
  input logic                           cfg_wr_en,
  input logic [psg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [psg_pkg::CFG_W-1:0]      cfg_data
);
  import psg_pkg::*;

  // A result waiting for the consumer stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before its transaction");

  // A waiting result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output payload changed while stalled");

  // The block takes one transaction at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  // A register write never creates a result.
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.cmd == CMD_WRITE && !out_valid |=> !out_valid)
    else $error("result appeared after a register write");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind psg_three_tone_noise_envelope psg_checker u_psg_checker (.*);
